FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the matrix inverse block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every clock edge outside reset.
`define MIC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define MIC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define MIC_ASSERT(lbl, clk, rst_n, prop, msg)
`define MIC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

FILE: rtl/mic_pkg.sv
// Shared constants, types and helper functions of the matrix inverse block.
`default_nettype none

package mic_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int MAX_SIZE  = 4;
    localparam int SIZE_W    = 3;
    localparam int IDX_W     = 2;
    localparam int DEPTH     = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = 2 * DATA_W + 2;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int COF_W     = DATA_W + 1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_FETCH_A,
        ST_FETCH_B,
        ST_MULT,
        ST_ACCUM,
        ST_ELEM,
        ST_COF,
        ST_DET_DONE,
        ST_OUT_RD,
        ST_OUT_CAP,
        ST_DIV,
        ST_OUT
    } state_t;

    // What the current product feeds.
    typedef enum logic [1:0] {
        K_PAIR,
        K_OUTER,
        K_DET,
        K_ELEM
    } kind_t;

    typedef struct packed {
        logic                     flag;
        logic signed [DATA_W-1:0] value;
    } sat_t;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [DATA_W-1:0] den;
    } div_req_t;

    // Clamp a wide sum to the data width and report whether it was clipped.
    function automatic sat_t clamp_acc(input logic signed [ACC_W-1:0] v);
        sat_t r;
        r.flag  = 1'b0;
        r.value = v[DATA_W-1:0];
        if (!(&v[ACC_W-1:DATA_W-1]) && (|v[ACC_W-1:DATA_W-1])) begin
            r.flag = 1'b1;
            if (v[ACC_W-1]) begin
                r.value = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                r.value = {1'b0, {(DATA_W-1){1'b1}}};
            end
        end
        return r;
    endfunction

    // The k-th index of 0..3 once index x is left out.
    function automatic logic [IDX_W-1:0] skip_idx(input logic [IDX_W-1:0] k,
                                                  input logic [IDX_W-1:0] x);
        return (k < x) ? k : (k + IDX_W'(1));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mic_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module mic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/mic_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module mic_mul (
    input  wire logic                               clk,
    input  wire logic signed [mic_pkg::DATA_W-1:0]  a,
    input  wire logic signed [mic_pkg::DATA_W-1:0]  b,
    output logic      signed [mic_pkg::PROD_W-1:0]  p
);

    // The product is registered and ready in the cycle after the operands.
    always_ff @(posedge clk) begin
        p <= a * b;
    end

endmodule

`default_nettype wire

FILE: rtl/mic_div.sv
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit a cycle.
`default_nettype none

module mic_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire mic_pkg::div_req_t          req,
    output logic                            done,
    output logic [mic_pkg::NUM_W-1:0]       quo
);

    localparam int CNT_W = $clog2(mic_pkg::NUM_W + 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [mic_pkg::NUM_W-1:0]     num_reg, num_next;
    logic [mic_pkg::DATA_W-1:0]    den_reg, den_next;
    logic [mic_pkg::DATA_W-1:0]    rem_reg, rem_next;
    logic [mic_pkg::DATA_W:0]      rem_sh;
    logic [mic_pkg::DATA_W:0]      diff;
    logic                          ge;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        rem_sh = {rem_reg, num_reg[mic_pkg::NUM_W-1]};
        diff   = rem_sh - {1'b0, den_reg};
        ge     = !diff[mic_pkg::DATA_W];
    end

    // Iteration control.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = ge ? diff[mic_pkg::DATA_W-1:0] : rem_sh[mic_pkg::DATA_W-1:0];
            num_next = {num_reg[mic_pkg::NUM_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(mic_pkg::NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

`default_nettype wire

FILE: rtl/matrix_inverse_cofactor_unit.sv
// Top level of the matrix inverse block: load, cofactor sequencer and result output.
//
//  Channel | Direction | Ports                                          | Moves
//  cfg     | in        | cfg_valid, cfg_ready, cfg_data                 | matrix size
//  s       | in        | s_valid, s_ready, s_element                    | one matrix element
//  m       | out       | m_valid, m_ready, m_inverse_element, m_determinant,
//          |           | m_singular, m_saturated, m_last                | one inverse element
//
// Loading takes n*n transactions in all, one for each element.
// Every product goes through the one shared multiplier in order: two store reads,
// multiply, accumulate; each row-0 cofactor also feeds one determinant term.
// Each result is then read from the cofactor store and divided by the determinant
// in the bit-serial divider (skipped when singular), and held until the receiver
// takes it.
// The input side is stalled from the last element until the last result is taken.
// Reset clears the control state and sets the size to 4; cfg is always ready.
`default_nettype none
`include "assert_macros.svh"

module matrix_inverse_cofactor_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [mic_pkg::SIZE_W-1:0]         cfg_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [mic_pkg::DATA_W-1:0]  s_element,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [mic_pkg::DATA_W-1:0]       m_inverse_element,
    output logic signed [mic_pkg::DATA_W-1:0]       m_determinant,
    output logic                                    m_singular,
    output logic                                    m_saturated,
    output logic                                    m_last
);

    localparam int DW = mic_pkg::DATA_W;
    localparam int AW = mic_pkg::ADDR_W;
    localparam int IW = mic_pkg::IDX_W;
    localparam int CW = mic_pkg::ACC_W;

    mic_pkg::state_t state_reg, state_next;
    mic_pkg::kind_t  kind_reg, kind_next;

    logic [mic_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [AW-1:0]              load_cnt_reg, load_cnt_next;
    logic [IW-1:0]              ci_reg, ci_next;
    logic [IW-1:0]              cj_reg, cj_next;
    logic [IW-1:0]              jj_reg, jj_next;
    logic                       pt_reg, pt_next;
    logic signed [CW-1:0]       acc2_reg, acc2_next;
    logic signed [CW-1:0]       acc3_reg, acc3_next;
    logic signed [CW-1:0]       det_acc_reg, det_acc_next;
    logic signed [DW-1:0]       m2_reg, m2_next;
    logic signed [DW-1:0]       d_reg, d_next;
    logic                       mflag_reg, mflag_next;
    logic                       det_flag_reg, det_flag_next;
    logic signed [DW-1:0]       det_reg, det_next;
    logic signed [DW-1:0]       opa_reg, opa_next;
    logic [AW-1:0]              k_reg, k_next;
    logic signed [DW-1:0]       cv_reg, cv_next;
    logic                       cflag_reg, cflag_next;
    logic signed [DW-1:0]       inv_reg, inv_next;
    logic                       sat_reg, sat_next;

    // Size and index helpers.
    logic [mic_pkg::SIZE_W-1:0] n_eff;
    logic [IW-1:0]              nm1;
    logic [AW-1:0]              nn_m1;
    logic                       m3, m1;
    logic [IW-1:0]              r0, rb, rb1, c0, x0, x1, c_jj;
    logic [AW-1:0]              addr_a, addr_b;
    logic                       load_last, cof_last;

    // Store, multiplier and divider connections.
    logic                       elem_we;
    logic [AW-1:0]              elem_raddr;
    logic [DW-1:0]              elem_rd;
    logic                       cof_we;
    logic [mic_pkg::COF_W-1:0]  cof_wdata, cof_rd;
    logic signed [DW-1:0]       mul_b;
    logic signed [mic_pkg::PROD_W-1:0] mul_p;
    mic_pkg::div_req_t          div_req;
    logic                       div_done;
    logic [mic_pkg::NUM_W-1:0]  div_quo;

    // Arithmetic around the shared units.
    logic signed [CW-1:0]       term, base, sum, neg_d, q_ext, q_signed;
    logic                       add_term, q_neg;
    mic_pkg::sat_t              sum_c, neg_c, q_c, det_c;
    logic signed [DW-1:0]       cof_val, cv_rd;
    logic [DW-1:0]              cv_mag, det_mag;

    function automatic logic [AW-1:0] elem_addr(input logic [IW-1:0] row,
                                                input logic [IW-1:0] col,
                                                input logic [mic_pkg::SIZE_W-1:0] n);
        return AW'(AW'(row) * AW'(n) + AW'(col));
    endfunction

    // Effective size and the row and column sets of the current minor.
    always_comb begin
        if (size_reg < mic_pkg::SIZE_W'(2)) begin
            n_eff = mic_pkg::SIZE_W'(2);
        end else if (size_reg > mic_pkg::SIZE_W'(mic_pkg::MAX_SIZE)) begin
            n_eff = mic_pkg::SIZE_W'(mic_pkg::MAX_SIZE);
        end else begin
            n_eff = size_reg;
        end
        nm1   = IW'(n_eff - mic_pkg::SIZE_W'(1));
        nn_m1 = AW'(AW'(n_eff) * AW'(n_eff) - AW'(1));
        m3    = (n_eff == mic_pkg::SIZE_W'(4));
        m1    = (n_eff == mic_pkg::SIZE_W'(2));
        r0    = mic_pkg::skip_idx(IW'(0), ci_reg);
        rb    = mic_pkg::skip_idx(m3 ? IW'(1) : IW'(0), ci_reg);
        rb1   = mic_pkg::skip_idx(m3 ? IW'(2) : IW'(1), ci_reg);
        c0    = mic_pkg::skip_idx(IW'(0), cj_reg);
        c_jj  = mic_pkg::skip_idx(jj_reg, cj_reg);
        x0    = m3 ? mic_pkg::skip_idx(mic_pkg::skip_idx(IW'(0), jj_reg), cj_reg)
                   : c0;
        x1    = m3 ? mic_pkg::skip_idx(mic_pkg::skip_idx(IW'(1), jj_reg), cj_reg)
                   : mic_pkg::skip_idx(IW'(1), cj_reg);
        load_last = (load_cnt_reg == nn_m1);
        cof_last  = (ci_reg == nm1) && (cj_reg == nm1);
    end

    // Operand addresses for the current product.
    always_comb begin
        addr_a = elem_addr(r0, c0, n_eff);
        addr_b = elem_addr(rb1, x1, n_eff);
        case (kind_reg)
            mic_pkg::K_PAIR: begin
                addr_a = pt_reg ? elem_addr(rb, x1, n_eff) : elem_addr(rb, x0, n_eff);
                addr_b = pt_reg ? elem_addr(rb1, x0, n_eff) : elem_addr(rb1, x1, n_eff);
            end
            mic_pkg::K_OUTER: addr_a = elem_addr(r0, c_jj, n_eff);
            mic_pkg::K_DET:   addr_a = elem_addr(IW'(0), cj_reg, n_eff);
            mic_pkg::K_ELEM:  addr_a = elem_addr(r0, c0, n_eff);
            default:          addr_a = elem_addr(r0, c0, n_eff);
        endcase
        elem_raddr = (state_reg == mic_pkg::ST_FETCH_B) ? addr_b : addr_a;
    end

    // Accumulation of the floored product and the clamps.
    always_comb begin
        term = CW'(mul_p) >>> mic_pkg::FRAC_BITS;
        case (kind_reg)
            mic_pkg::K_PAIR: begin
                base     = acc2_reg;
                add_term = !pt_reg;
            end
            mic_pkg::K_OUTER: begin
                base     = acc3_reg;
                add_term = !jj_reg[0];
            end
            mic_pkg::K_DET: begin
                base     = det_acc_reg;
                add_term = !cj_reg[0];
            end
            default: begin
                base     = acc2_reg;
                add_term = 1'b1;
            end
        endcase
        sum   = add_term ? (base + term) : (base - term);
        sum_c = mic_pkg::clamp_acc(sum);
        det_c = mic_pkg::clamp_acc(det_acc_reg);
        neg_d = -CW'(d_reg);
        neg_c = mic_pkg::clamp_acc(neg_d);
        cof_val   = ((ci_reg[0] ^ cj_reg[0]) != 1'b0) ? neg_c.value : d_reg;
        cof_wdata = {mflag_reg | (((ci_reg[0] ^ cj_reg[0]) != 1'b0) & neg_c.flag), cof_val};
        case (kind_reg)
            mic_pkg::K_PAIR:  mul_b = $signed(elem_rd);
            mic_pkg::K_OUTER: mul_b = m2_reg;
            default:          mul_b = d_reg;
        endcase
        cv_rd   = $signed(cof_rd[DW-1:0]);
        cv_mag  = cv_rd[DW-1] ? DW'(-cv_rd) : DW'(cv_rd);
        det_mag = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
        q_neg    = cv_reg[DW-1] ^ det_reg[DW-1];
        q_ext    = $signed(CW'(div_quo));
        q_signed = q_neg ? -q_ext : q_ext;
        q_c      = mic_pkg::clamp_acc(q_signed);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mic_pkg::ST_LOAD: begin
                if (s_valid && load_last) begin
                    state_next = mic_pkg::ST_FETCH_A;
                end
            end
            mic_pkg::ST_FETCH_A: begin
                state_next = (kind_reg == mic_pkg::K_ELEM) ? mic_pkg::ST_ELEM
                                                           : mic_pkg::ST_FETCH_B;
            end
            mic_pkg::ST_FETCH_B: state_next = mic_pkg::ST_MULT;
            mic_pkg::ST_MULT:    state_next = mic_pkg::ST_ACCUM;
            mic_pkg::ST_ACCUM: begin
                case (kind_reg)
                    mic_pkg::K_PAIR: begin
                        state_next = (!pt_reg || m3) ? mic_pkg::ST_FETCH_A : mic_pkg::ST_COF;
                    end
                    mic_pkg::K_OUTER: begin
                        state_next = (jj_reg != IW'(2)) ? mic_pkg::ST_FETCH_A
                                                        : mic_pkg::ST_COF;
                    end
                    default: begin
                        state_next = cof_last ? mic_pkg::ST_DET_DONE : mic_pkg::ST_FETCH_A;
                    end
                endcase
            end
            mic_pkg::ST_ELEM: state_next = mic_pkg::ST_COF;
            mic_pkg::ST_COF: begin
                if (ci_reg == IW'(0)) begin
                    state_next = mic_pkg::ST_FETCH_A;
                end else begin
                    state_next = cof_last ? mic_pkg::ST_DET_DONE : mic_pkg::ST_FETCH_A;
                end
            end
            mic_pkg::ST_DET_DONE: state_next = mic_pkg::ST_OUT_RD;
            mic_pkg::ST_OUT_RD:   state_next = mic_pkg::ST_OUT_CAP;
            mic_pkg::ST_OUT_CAP: begin
                state_next = (det_reg == '0) ? mic_pkg::ST_OUT : mic_pkg::ST_DIV;
            end
            mic_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = mic_pkg::ST_OUT;
                end
            end
            mic_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = (k_reg == nn_m1) ? mic_pkg::ST_LOAD : mic_pkg::ST_OUT_RD;
                end
            end
            default: state_next = mic_pkg::ST_LOAD;
        endcase
    end

    // Datapath and counter updates.
    always_comb begin
        size_next     = size_reg;
        load_cnt_next = load_cnt_reg;
        kind_next     = kind_reg;
        ci_next       = ci_reg;
        cj_next       = cj_reg;
        jj_next       = jj_reg;
        pt_next       = pt_reg;
        acc2_next     = acc2_reg;
        acc3_next     = acc3_reg;
        det_acc_next  = det_acc_reg;
        m2_next       = m2_reg;
        d_next        = d_reg;
        mflag_next    = mflag_reg;
        det_flag_next = det_flag_reg;
        det_next      = det_reg;
        opa_next      = opa_reg;
        k_next        = k_reg;
        cv_next       = cv_reg;
        cflag_next    = cflag_reg;
        inv_next      = inv_reg;
        sat_next      = sat_reg;
        elem_we       = 1'b0;
        cof_we        = 1'b0;
        div_req       = '0;

        // A size write restarts loading.
        if (cfg_valid) begin
            size_next     = cfg_data;
            load_cnt_next = '0;
        end

        case (state_reg)
            mic_pkg::ST_LOAD: begin
                if (s_valid) begin
                    elem_we = 1'b1;
                    if (load_last) begin
                        load_cnt_next = '0;
                        det_acc_next  = '0;
                        det_flag_next = 1'b0;
                        ci_next       = '0;
                        cj_next       = '0;
                    end else begin
                        load_cnt_next = load_cnt_reg + AW'(1);
                    end
                end
            end
            mic_pkg::ST_FETCH_B: opa_next = $signed(elem_rd);
            mic_pkg::ST_ACCUM: begin
                case (kind_reg)
                    mic_pkg::K_PAIR: begin
                        acc2_next = sum;
                        if (!pt_reg) begin
                            pt_next = 1'b1;
                        end else if (m3) begin
                            m2_next    = sum_c.value;
                            mflag_next = mflag_reg | sum_c.flag;
                            kind_next  = mic_pkg::K_OUTER;
                        end else begin
                            d_next     = sum_c.value;
                            mflag_next = mflag_reg | sum_c.flag;
                        end
                    end
                    mic_pkg::K_OUTER: begin
                        acc3_next = sum;
                        if (jj_reg != IW'(2)) begin
                            jj_next   = jj_reg + IW'(1);
                            kind_next = mic_pkg::K_PAIR;
                            pt_next   = 1'b0;
                            acc2_next = '0;
                        end else begin
                            d_next     = sum_c.value;
                            mflag_next = mflag_reg | sum_c.flag;
                        end
                    end
                    default: det_acc_next = sum;
                endcase
            end
            mic_pkg::ST_ELEM: d_next = $signed(elem_rd);
            mic_pkg::ST_COF: begin
                cof_we = 1'b1;
                if (ci_reg == IW'(0)) begin
                    det_flag_next = det_flag_reg | mflag_reg;
                    kind_next     = mic_pkg::K_DET;
                end
            end
            mic_pkg::ST_DET_DONE: begin
                det_acc_next  = det_acc_reg;
                det_next      = det_c.value;
                det_flag_next = det_flag_reg | det_c.flag;
                k_next        = '0;
            end
            mic_pkg::ST_OUT_CAP: begin
                cv_next    = cv_rd;
                cflag_next = cof_rd[DW];
                if (det_reg == '0) begin
                    inv_next = '0;
                    sat_next = det_flag_reg;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = mic_pkg::NUM_W'(cv_mag) << mic_pkg::FRAC_BITS;
                    div_req.den   = det_mag;
                end
            end
            mic_pkg::ST_DIV: begin
                if (div_done) begin
                    inv_next = q_c.value;
                    sat_next = det_flag_reg | cflag_reg | q_c.flag;
                end
            end
            mic_pkg::ST_OUT: begin
                if (m_ready && (k_reg != nn_m1)) begin
                    k_next = k_reg + AW'(1);
                end
            end
            default: ;
        endcase

        // Step to the next cofactor once this one, and its determinant term, are done.
        if (((state_reg == mic_pkg::ST_COF) && (ci_reg != IW'(0))) ||
            ((state_reg == mic_pkg::ST_ACCUM) && (kind_reg == mic_pkg::K_DET))) begin
            if (!cof_last) begin
                if (cj_reg == nm1) begin
                    cj_next = '0;
                    ci_next = ci_reg + IW'(1);
                end else begin
                    cj_next = cj_reg + IW'(1);
                end
            end
        end

        // Fresh minor state at the start of every cofactor.
        if (((state_reg == mic_pkg::ST_LOAD) && s_valid && load_last) ||
            (((state_reg == mic_pkg::ST_COF) && (ci_reg != IW'(0))) ||
             ((state_reg == mic_pkg::ST_ACCUM) && (kind_reg == mic_pkg::K_DET)))) begin
            acc2_next  = '0;
            acc3_next  = '0;
            mflag_next = 1'b0;
            jj_next    = '0;
            pt_next    = 1'b0;
            kind_next  = m1 ? mic_pkg::K_ELEM : mic_pkg::K_PAIR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mic_pkg::ST_LOAD;
            size_reg     <= mic_pkg::SIZE_RESET;
            load_cnt_reg <= '0;
            kind_reg     <= mic_pkg::K_PAIR;
            ci_reg       <= '0;
            cj_reg       <= '0;
            jj_reg       <= '0;
            pt_reg       <= 1'b0;
            k_reg        <= '0;
        end else begin
            state_reg    <= state_next;
            size_reg     <= size_next;
            load_cnt_reg <= load_cnt_next;
            kind_reg     <= kind_next;
            ci_reg       <= ci_next;
            cj_reg       <= cj_next;
            jj_reg       <= jj_next;
            pt_reg       <= pt_next;
            k_reg        <= k_next;
        end
        acc2_reg     <= acc2_next;
        acc3_reg     <= acc3_next;
        det_acc_reg  <= det_acc_next;
        m2_reg       <= m2_next;
        d_reg        <= d_next;
        mflag_reg    <= mflag_next;
        det_flag_reg <= det_flag_next;
        det_reg      <= det_next;
        opa_reg      <= opa_next;
        cv_reg       <= cv_next;
        cflag_reg    <= cflag_next;
        inv_reg      <= inv_next;
        sat_reg      <= sat_next;
    end

    // Matrix element store.
    mic_ram #(
        .WIDTH (DW),
        .DEPTH (mic_pkg::DEPTH)
    ) u_elem_ram (
        .clk   (aclk),
        .we    (elem_we),
        .waddr (load_cnt_reg),
        .wdata (s_element),
        .raddr (elem_raddr),
        .rdata (elem_rd)
    );

    // Cofactor store, written in transposed order so results read out in sequence.
    mic_ram #(
        .WIDTH (mic_pkg::COF_W),
        .DEPTH (mic_pkg::DEPTH)
    ) u_cof_ram (
        .clk   (aclk),
        .we    (cof_we),
        .waddr (elem_addr(cj_reg, ci_reg, n_eff)),
        .wdata (cof_wdata),
        .raddr (k_reg),
        .rdata (cof_rd)
    );

    mic_mul u_mul (
        .clk (aclk),
        .a   (opa_reg),
        .b   (mul_b),
        .p   (mul_p)
    );

    mic_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Handshakes and result fields.
    assign cfg_ready         = 1'b1;
    assign s_ready           = (state_reg == mic_pkg::ST_LOAD);
    assign m_valid           = (state_reg == mic_pkg::ST_OUT);
    assign m_inverse_element = inv_reg;
    assign m_determinant     = det_reg;
    assign m_singular        = (det_reg == '0);
    assign m_saturated       = sat_reg;
    assign m_last            = (k_reg == nn_m1);

    `MIC_ASSERT(a_no_overlap, aclk, aresetn, !(s_ready && m_valid), "input taken while a result waits")
    `MIC_ASSERT_NEXT(a_last_reopens, aclk, aresetn, m_valid && m_ready && m_last, s_ready, "input not reopened after last result")
    `MIC_ASSERT(a_singular_zero, aclk, aresetn, (m_valid && m_singular) |-> (m_inverse_element == '0), "singular result not zero")
    `MIC_ASSERT(a_div_phase, aclk, aresetn, div_done |-> (state_reg == mic_pkg::ST_DIV), "divider finished outside the divide phase")

endmodule

`default_nettype wire

FILE: test/tb_matrix_inverse_cofactor_unit.sv
// Self-checking testbench for the matrix inverse cofactor unit.
`timescale 1ns / 100ps
`default_nettype none

module tb_matrix_inverse_cofactor_unit;

    localparam int DATA_W    = mic_pkg::DATA_W;
    localparam int SIZE_W    = mic_pkg::SIZE_W;
    localparam int FRAC_BITS = mic_pkg::FRAC_BITS;
    localparam int MAX_SIZE  = mic_pkg::MAX_SIZE;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    // One expected inverse element.
    typedef struct {
        logic signed [DATA_W-1:0] inverse_element;
        logic signed [DATA_W-1:0] determinant;
        logic                     singular;
        logic                     saturated;
        logic                     last;
    } inverse_elem_t;

    // One row of the directed table.
    typedef struct {
        logic [SIZE_W-1:0]        size_setting;
        logic signed [DATA_W-1:0] elems[16];
        logic                     typed_in;
        logic signed [DATA_W-1:0] typed_det;
        logic                     typed_singular;
    } directed_row_t;

    logic aclk;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [SIZE_W-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic signed [DATA_W-1:0] s_element;
    logic m_valid;
    logic m_ready;
    logic signed [DATA_W-1:0] m_inverse_element;
    logic signed [DATA_W-1:0] m_determinant;
    logic m_singular;
    logic m_saturated;
    logic m_last;

    // Predictor state.
    longint  pred_store[16];
    int      pred_load_count;
    int      pred_size_reg;

    inverse_elem_t expected_inverse_q[$];
    int  error_count;
    int  idle_cycles;
    bit  stall_enable;

    matrix_inverse_cofactor_unit DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_element         (s_element),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_inverse_element (m_inverse_element),
        .m_determinant     (m_determinant),
        .m_singular        (m_singular),
        .m_saturated       (m_saturated),
        .m_last            (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Clamp to the signed data width and flag a clip.
    function automatic longint clamp_word(input longint v, inout bit clipped);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (DATA_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            clipped = 1'b1;
            return hi;
        end
        if (v < lo) begin
            clipped = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Arithmetic shift right by the fraction width, which floors.
    function automatic longint floor_frac(input longint x);
        return x >>> FRAC_BITS;
    endfunction

    function automatic longint add_clip64(input longint a, input longint b);
        longint s;
        s = a + b;
        if (b > 0 && s < a) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (b < 0 && s > a) return 64'sh8000_0000_0000_0000;
        return s;
    endfunction

    function automatic int active_size();
        int n;
        n = pred_size_reg;
        if (n < 2) n = 2;
        if (n > MAX_SIZE) n = MAX_SIZE;
        return n;
    endfunction

    // Determinant of the submatrix picked by the row and column lists,
    // expanded along its first row.
    function automatic longint minor_det(input int rows[4], input int cols[4], input int k,
                                         input int n, inout bit clipped);
        longint acc;
        longint sub_det;
        longint term;
        int     sub_cols[4];
        int     sub_rows[4];
        int     m;
        acc = 0;
        if (k == 1) return pred_store[(rows[0] * n + cols[0]) & 15];
        for (int t = 0; t < 3; t++) sub_rows[t] = rows[t + 1];
        sub_rows[3] = 0;
        for (int j = 0; j < k; j++) begin
            m = 0;
            sub_cols = '{0, 0, 0, 0};
            for (int t = 0; t < k; t++) begin
                if (t != j) begin
                    sub_cols[m] = cols[t];
                    m++;
                end
            end
            sub_det = minor_det(sub_rows, sub_cols, k - 1, n, clipped);
            term = floor_frac(pred_store[(rows[0] * n + cols[j]) & 15] * sub_det);
            if (j % 2 == 1) term = -term;
            acc = add_clip64(acc, term);
        end
        return clamp_word(acc, clipped);
    endfunction

    // Take one element; on the final one of a matrix queue its inverse.
    task automatic predict_inverse(input logic signed [DATA_W-1:0] elem);
        int            n;
        int            all_idx[4];
        int            rows[4];
        int            cols[4];
        longint        cof[16];
        bit            cof_clip[16];
        longint        det;
        longint        d;
        longint        cv;
        longint        q;
        bit            det_clip;
        bit            f;
        int            m;
        inverse_elem_t e;
        n = active_size();
        all_idx = '{0, 1, 2, 3};
        det_clip = 1'b0;
        pred_store[pred_load_count & 15] = longint'(elem);
        pred_load_count = (pred_load_count + 1) & 31;
        if (pred_load_count < n * n) return;
        pred_load_count = 0;
        det = minor_det(all_idx, all_idx, n, n, det_clip);
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                f = 1'b0;
                rows = '{0, 0, 0, 0};
                cols = '{0, 0, 0, 0};
                m = 0;
                for (int t = 0; t < n; t++) if (t != i) begin rows[m] = t; m++; end
                m = 0;
                for (int t = 0; t < n; t++) if (t != j) begin cols[m] = t; m++; end
                d = minor_det(rows, cols, n - 1, n, f);
                if ((i + j) % 2 == 1) d = clamp_word(-d, f);
                cof[i * n + j] = d;
                cof_clip[i * n + j] = f;
            end
        end
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                q = 0;
                f = det_clip;
                if (det != 0) begin
                    cv = cof[c * n + r];
                    q = ((cv < 0 ? -cv : cv) <<< FRAC_BITS) / (det < 0 ? -det : det);
                    if ((cv < 0) != (det < 0)) q = -q;
                    f = f | cof_clip[c * n + r];
                    q = clamp_word(q, f);
                end
                e.inverse_element = q[DATA_W-1:0];
                e.determinant     = det[DATA_W-1:0];
                e.singular        = (det == 0);
                e.saturated       = f;
                e.last            = (r * n + c == n * n - 1);
                expected_inverse_q.push_back(e);
            end
        end
    endtask

    // Send one element and predict on acceptance. Valid drops only for a
    // random gap or after the final element of a burst.
    task automatic send_element(input logic signed [DATA_W-1:0] elem, input bit final_one);
        s_valid   <= 1'b1;
        s_element <= elem;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_inverse(elem);
        @(negedge aclk);
        if (final_one || ($urandom_range(0, 5) == 0)) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
    endtask

    // Wait until every expected result has been taken and the block is quiet.
    task automatic drain_results();
        while (expected_inverse_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Write the size register while the block is idle.
    task automatic write_size(input logic [SIZE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        pred_size_reg   = value;
        pred_load_count = 0;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_matrix(input logic signed [DATA_W-1:0] elems[16]);
        int n;
        n = active_size();
        for (int k = 0; k < n * n; k++) send_element(elems[k], (k == n * n - 1));
    endtask

    // Random element: mostly moderate values so inverses stay meaningful.
    function automatic logic signed [DATA_W-1:0] random_element();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh8000_0000;
            3: return 32'sh0000_0000;
            default: return DATA_W'(signed'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        endcase
    endfunction

    // Receiver stall pattern and result checks.
    always @(negedge aclk) begin
        if (!stall_enable) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        inverse_elem_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_inverse_q.size() == 0) begin
                $error("unexpected result transaction, inverse_element %0d", m_inverse_element);
                error_count++;
            end else begin
                e = expected_inverse_q.pop_front();
                if (m_inverse_element !== e.inverse_element) begin
                    $error("inverse_element: expected %0d, actual %0d",
                           e.inverse_element, m_inverse_element);
                    error_count++;
                end
                if (m_determinant !== e.determinant) begin
                    $error("determinant: expected %0d, actual %0d", e.determinant, m_determinant);
                    error_count++;
                end
                if (m_singular !== e.singular) begin
                    $error("singular: expected %0d, actual %0d", e.singular, m_singular);
                    error_count++;
                end
                if (m_saturated !== e.saturated) begin
                    $error("saturated: expected %0d, actual %0d", e.saturated, m_saturated);
                    error_count++;
                end
                if (m_last !== e.last) begin
                    $error("last: expected %0d, actual %0d", e.last, m_last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on any channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Stimulus.
    initial begin
        directed_row_t table_rows[$];
        directed_row_t row;
        logic signed [DATA_W-1:0] elems[16];
        inverse_elem_t typed;
        int n;
        int sent;
        int table_errors;
        table_errors    = 0;
        stall_enable    = 1'b0;
        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_element       = '0;
        pred_store      = '{default: 0};
        pred_load_count = 0;
        pred_size_reg   = mic_pkg::SIZE_RESET;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed table: identity at reset size, zero matrix, extremes, odd sizes.
        row.size_setting = 3'd4;
        row.elems = '{default: 0};
        for (int k = 0; k < 4; k++) row.elems[k * 5] = 32'sh0001_0000;
        row.typed_in = 1'b1;
        row.typed_det = 32'sh0001_0000;
        row.typed_singular = 1'b0;
        table_rows.push_back(row);
        row.elems = '{default: 0};
        row.typed_det = 0;
        row.typed_singular = 1'b1;
        table_rows.push_back(row);
        row.size_setting = 3'd2;
        row.elems = '{default: 0};
        row.elems[0] = 32'sh7FFF_FFFF;
        row.elems[1] = 32'sh8000_0000;
        row.elems[2] = 32'sh8000_0000;
        row.elems[3] = 32'sh7FFF_FFFF;
        row.typed_in = 1'b0;
        table_rows.push_back(row);
        row.size_setting = 3'd0;
        row.elems[0] = 32'sh0002_0000;
        row.elems[1] = 32'sh0001_0000;
        row.elems[2] = 32'sh0001_0000;
        row.elems[3] = 32'sh0001_0000;
        table_rows.push_back(row);
        row.size_setting = 3'd7;
        row.elems = '{32'sh0001, 32'sh0002, 32'sh0003, 32'sh0004, 32'sh8000_0000, 0, 0, 0,
                      32'sh0003_0000, 32'sh0001_0000, 32'sh7FFF_FFFF, 0, 1, 2, 3, 4};
        table_rows.push_back(row);
        row.size_setting = 3'd3;
        row.elems = '{default: 0};
        row.elems[0] = 32'sh0001_0000;
        row.elems[1] = 32'sh0002_0000;
        row.elems[2] = 32'sh0003_0000;
        row.elems[3] = 32'sh0000_0000;
        row.elems[4] = 32'sh0001_0000;
        row.elems[5] = 32'sh0004_0000;
        row.elems[6] = 32'sh0005_0000;
        row.elems[7] = 32'sh0006_0000;
        row.elems[8] = 32'sh0000_0000;
        table_rows.push_back(row);

        foreach (table_rows[r]) begin
            drain_results();
            write_size(table_rows[r].size_setting);
            send_matrix(table_rows[r].elems);
            if (table_rows[r].typed_in) begin
                // Identity and zero matrices: determinant read off directly.
                foreach (expected_inverse_q[k]) begin
                    typed = expected_inverse_q[k];
                    if (typed.determinant !== table_rows[r].typed_det ||
                        typed.singular !== table_rows[r].typed_singular) begin
                        $error("determinant: expected %0d, actual %0d",
                               table_rows[r].typed_det, typed.determinant);
                        table_errors++;
                    end
                end
            end
        end

        // A size write in the middle of a load restarts loading.
        drain_results();
        write_size(3'd3);
        for (int k = 0; k < 4; k++) send_element(random_element(), (k == 3));
        write_size(3'd2);

        // Random part: matrices at changing sizes with receiver stalls.
        stall_enable = 1'b1;
        sent = 0;
        while (sent < 190) begin
            if ($urandom_range(0, 3) == 0) begin
                drain_results();
                write_size(SIZE_W'($urandom_range(0, 7)));
            end
            n = active_size();
            for (int k = 0; k < 16; k++) elems[k] = random_element();
            send_matrix(elems);
            sent += n * n;
            if ($urandom_range(0, 9) == 0) drain_results();
        end

        drain_results();
        if (error_count == 0 && table_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
